@@ hw/rtl/slsfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfr_pkg
// Shared types and constants for the sync/length/checksum frame receiver.
// ----------------------------------------------------------------------------
package slsfr_pkg;

  // Reset values of the configuration registers.
  localparam logic [7:0]  SYNC_VALUE_RESET    = 8'hAA;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1500;

  // Register indexes, taken from paddr[2] (byte addresses 0 and 4).
  localparam logic REG_SYNC_VALUE    = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  // Width of the APB address bus.
  localparam int unsigned ADDR_W = 3;

  // Kind of one result item.
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_CHKERR  = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_LENERR  = 3'd4
  } kind_t;

  // Current configuration as seen by the receiver.
  typedef struct packed {
    logic [7:0]  sync_value;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

@@ hw/rtl/slsfr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfr_cfg
// APB register file holding the sync byte value and the timeout limit.
// ----------------------------------------------------------------------------
module slsfr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slsfr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output slsfr_pkg::cfg_t               cfg
);

  logic wr_en;
  logic reg_sel;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value    <= slsfr_pkg::SYNC_VALUE_RESET;
      cfg.timeout_ticks <= slsfr_pkg::TIMEOUT_TICKS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        slsfr_pkg::REG_SYNC_VALUE:    cfg.sync_value    <= pwdata[7:0];
        slsfr_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_sel)
      slsfr_pkg::REG_SYNC_VALUE:    prdata = {24'd0, cfg.sync_value};
      slsfr_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg.timeout_ticks};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/sync_length_sum_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit
// Deframes a byte stream of sync, length, payload and checksum bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one item per received byte (tuser = 0, tdata =
//   the byte) or per timer tick (tuser = 1). A frame is a sync byte, a length
//   byte L, L-1 payload bytes and a checksum equal to the 8-bit sum of L and
//   the payload. Each payload byte leaves on the output stream with its index
//   and the frame's payload count; the checksum byte gives an accept or a
//   checksum-error item. A byte arriving inside a frame after more than
//   timeout_ticks ticks since sync aborts the frame; a length of zero gives a
//   length-error item. Ticks, sync and nonzero length bytes give no output
//   item. An accepted item's output item is registered for the next cycle, and
//   one item is taken in every cycle unless the output stalls. The output
//   register is the only stage: while it holds an item that the receiver does
//   not take, the input stalls. Synchronous reset returns it to idle, clears
//   the timer and loads the register defaults (sync 0xAA, timeout 1500 ticks).
// ----------------------------------------------------------------------------
module sync_length_sum_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slsfr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]                    s_axis_tuser,  // [0] req_type
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [15:8] out_index, [23:16] frame_len
  output logic [23:0]                   m_axis_tdata,
  output logic [2:0]                    m_axis_tuser   // [2:0] out_kind
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  slsfr_pkg::cfg_t cfg;

  phase_t      phase, phase_next;
  logic [7:0]  length_seen, length_seen_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] ticks_since_sync, ticks_since_sync_next;

  logic             s_fire;
  logic             is_tick;
  logic [7:0]       rx_byte;
  logic [7:0]       flen_cur;
  logic             res_valid;
  slsfr_pkg::kind_t res_kind;
  logic [7:0]       res_byte;
  logic [7:0]       res_index;
  logic [7:0]       res_flen;

  slsfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take a new item whenever the output register is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = s_axis_tuser[0];
  assign rx_byte       = s_axis_tdata;

  // Payload count of the current frame; zero until the length is known.
  assign flen_cur = (phase == PH_LEN) ? 8'd0 : 8'(length_seen - 8'd1);

  // Frame decoding for one item.
  always_comb begin
    phase_next            = phase;
    length_seen_next      = length_seen;
    bytes_left_next       = bytes_left;
    running_sum_next      = running_sum;
    ticks_since_sync_next = ticks_since_sync;
    res_valid             = 1'b0;
    res_kind              = slsfr_pkg::KIND_PAYLOAD;
    res_byte              = 8'd0;
    res_index             = 8'd0;
    res_flen              = 8'd0;

    if (is_tick) begin
      if (ticks_since_sync != 16'hFFFF) begin
        ticks_since_sync_next = ticks_since_sync + 16'd1;
      end
    end else if (phase == PH_IDLE) begin
      if (rx_byte == cfg.sync_value) begin
        ticks_since_sync_next = 16'd0;
        phase_next            = PH_LEN;
        length_seen_next      = 8'd0;
        bytes_left_next       = 8'd0;
        running_sum_next      = 8'd0;
      end
    end else if (ticks_since_sync > cfg.timeout_ticks) begin
      // Late byte: drop it and abort the frame.
      phase_next = PH_IDLE;
      res_valid  = 1'b1;
      res_kind   = slsfr_pkg::KIND_TIMEOUT;
      res_flen   = flen_cur;
    end else begin
      case (phase)
        PH_LEN: begin
          if (rx_byte == 8'd0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = slsfr_pkg::KIND_LENERR;
          end else begin
            length_seen_next = rx_byte;
            running_sum_next = rx_byte;
            bytes_left_next  = 8'(rx_byte - 8'd1);
            phase_next       = (rx_byte != 8'd1) ? PH_DATA : PH_SUM;
          end
        end
        PH_DATA: begin
          running_sum_next = 8'(running_sum + rx_byte);
          bytes_left_next  = 8'(bytes_left - 8'd1);
          if (bytes_left == 8'd1) begin
            phase_next = PH_SUM;
          end
          res_valid = 1'b1;
          res_kind  = slsfr_pkg::KIND_PAYLOAD;
          res_byte  = rx_byte;
          res_index = 8'(flen_cur - bytes_left);
          res_flen  = flen_cur;
        end
        PH_SUM: begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res_kind   = (rx_byte == running_sum) ? slsfr_pkg::KIND_ACCEPT
                                                : slsfr_pkg::KIND_CHKERR;
          res_flen   = flen_cur;
        end
        default: ;
      endcase
    end
  end

  // Frame state, updated on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      length_seen      <= 8'd0;
      bytes_left       <= 8'd0;
      running_sum      <= 8'd0;
      ticks_since_sync <= 16'd0;
    end else if (s_fire) begin
      phase            <= phase_next;
      length_seen      <= length_seen_next;
      bytes_left       <= bytes_left_next;
      running_sum      <= running_sum_next;
      ticks_since_sync <= ticks_since_sync_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s_fire && res_valid) begin
      m_axis_tdata <= {res_flen, res_index, res_byte};
      m_axis_tuser <= res_kind;
    end
  end

  // A payload phase always has bytes still to come, within the frame length.
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != 8'd0) && (bytes_left < length_seen))
    else $error("payload phase with no bytes left");

  // The checksum phase is reached only once all payload bytes are in.
  a_sum_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUM) |-> (bytes_left == 8'd0))
    else $error("checksum phase with payload outstanding");

  // A tick never produces an output item.
  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && is_tick) |=> !m_axis_tvalid)
    else $error("tick produced an output item");

  // A payload item's index lies inside its frame.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == slsfr_pkg::KIND_PAYLOAD))
      |-> (m_axis_tdata[15:8] < m_axis_tdata[23:16]))
    else $error("payload index beyond frame length");

endmodule

@@ test/tb_sync_length_sum_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_sum_frame_receiver_unit
// Self-checking bench for the sync/length/checksum frame receiver.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the deframer state and of both
// registers. Every input item taken by the block is run through it, and every
// output item is compared field by field with the oldest predicted item.
// Stimulus is a short directed part followed by mostly well-formed frames with
// random lengths, payloads, ticks, bad checksums and cut-off frames, under
// several register settings and three mixes of sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sync_length_sum_frame_receiver_unit;

  localparam bit REQ_BYTE      = 1'b0;
  localparam bit REQ_TICK      = 1'b1;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int SHOWN_MAX     = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int LATE_TICKS    = 120;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_LEN,
    RX_DATA,
    RX_SUM
  } rx_phase_t;

  typedef struct {
    slsfr_pkg::kind_t kind;
    logic [7:0]       data_b;
    logic [7:0]       index;
    logic [7:0]       flen;
  } deframed_t;

  // Predicts deframer output items and checks the ones the block delivers.
  class deframe_scoreboard;
    logic [7:0]  sync_v;
    logic [15:0] timeout_v;
    rx_phase_t   phase;
    logic [7:0]  len_seen;
    logic [7:0]  bytes_left;
    logic [7:0]  running_sum;
    logic [15:0] ticks;
    deframed_t   pending_items[$];
    int          mismatches;
    int          rx_items;
    int          tx_items;
    int          kind_seen[5];

    function void reset_state();
      sync_v      = slsfr_pkg::SYNC_VALUE_RESET;
      timeout_v   = slsfr_pkg::TIMEOUT_TICKS_RESET;
      phase       = RX_IDLE;
      len_seen    = 8'd0;
      bytes_left  = 8'd0;
      running_sum = 8'd0;
      ticks       = 16'd0;
      mismatches  = 0;
      rx_items    = 0;
      tx_items    = 0;
      pending_items.delete();
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == slsfr_pkg::REG_SYNC_VALUE) begin
        sync_v = value[7:0];
      end else begin
        timeout_v = value[15:0];
      end
    endfunction

    function void queue_item(slsfr_pkg::kind_t k, logic [7:0] b, logic [7:0] idx,
                             logic [7:0] fl);
      deframed_t d;
      d.kind   = k;
      d.data_b = b;
      d.index  = idx;
      d.flen   = fl;
      pending_items.push_back(d);
    endfunction

    // Advances the deframer by one accepted input item.
    function void take_rx_item(bit is_tick, logic [7:0] b);
      logic [7:0] fl;
      logic [7:0] idx;
      rx_items++;
      if (is_tick) begin
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
        return;
      end
      // Outside a frame only the sync value matters.
      if (phase == RX_IDLE) begin
        if (b == sync_v) begin
          ticks       = 16'd0;
          phase       = RX_LEN;
          len_seen    = 8'd0;
          bytes_left  = 8'd0;
          running_sum = 8'd0;
        end
        return;
      end
      fl = (phase == RX_LEN) ? 8'd0 : len_seen - 8'd1;
      // A late byte is dropped and ends the frame.
      if (ticks > timeout_v) begin
        phase = RX_IDLE;
        queue_item(slsfr_pkg::KIND_TIMEOUT, 8'd0, 8'd0, fl);
        return;
      end
      case (phase)
        RX_LEN: begin
          if (b == 8'd0) begin
            phase = RX_IDLE;
            queue_item(slsfr_pkg::KIND_LENERR, 8'd0, 8'd0, 8'd0);
          end else begin
            len_seen    = b;
            running_sum = b;
            bytes_left  = b - 8'd1;
            phase       = (bytes_left != 8'd0) ? RX_DATA : RX_SUM;
          end
        end
        RX_DATA: begin
          idx         = fl - bytes_left;
          running_sum = running_sum + b;
          bytes_left  = bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = RX_SUM;
          queue_item(slsfr_pkg::KIND_PAYLOAD, b, idx, fl);
        end
        default: begin
          phase = RX_IDLE;
          queue_item((b == running_sum) ? slsfr_pkg::KIND_ACCEPT : slsfr_pkg::KIND_CHKERR,
                     8'd0, 8'd0, fl);
        end
      endcase
    endfunction

    // Compares one delivered output item with the oldest prediction.
    function void check_deframed(slsfr_pkg::kind_t k, logic [7:0] b, logic [7:0] idx,
                                 logic [7:0] fl);
      deframed_t want;
      tx_items++;
      if (pending_items.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected output item: kind %0d byte %02x index %0d len %0d",
                   k, b, idx, fl);
        return;
      end
      want = pending_items.pop_front();
      kind_seen[want.kind]++;
      if (want.kind !== k || want.data_b !== b || want.index !== idx ||
          want.flen !== fl) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display({"mismatch: expected kind %0d byte %02x index %0d len %0d, ",
                    "got kind %0d byte %02x index %0d len %0d"},
                   want.kind, want.data_b, want.index, want.flen, k, b, idx, fl);
      end
    endfunction

    function int outstanding();
      return pending_items.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [slsfr_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;  // [7:0] rx_byte
  logic [0:0]                     s_axis_tuser;  // [0] req_type
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // [7:0] out_byte, [15:8] out_index, [23:16] frame_len
  logic [23:0]                    m_axis_tdata;
  logic [2:0]                     m_axis_tuser;  // [2:0] out_kind

  deframe_scoreboard sb;
  int                tx_idle_pct = 17;
  int                rx_idle_pct = 79;
  int                tick_pct    = 5;
  int                hold_reqs   = 0;
  int                holds_done  = 0;
  int                frame_items = 0;
  int                stall_cycles = 0;
  logic [7:0]        cur_sync    = slsfr_pkg::SYNC_VALUE_RESET;

  sync_length_sum_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both handshakes are sampled at the edge, before any update from it lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_deframed(slsfr_pkg::kind_t'(m_axis_tuser), m_axis_tdata[7:0],
                          m_axis_tdata[15:8], m_axis_tdata[23:16]);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_rx_item(s_axis_tuser[0], s_axis_tdata);
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = holds_done + 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one input item, with random gaps ahead of it, until it is taken.
  task automatic send_item(bit is_tick, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_tick;
    s_axis_tdata  <= is_tick ? 8'($urandom) : b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Holds the input back until every predicted item has been delivered.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_register(idx, value);
    if (idx == slsfr_pkg::REG_SYNC_VALUE) cur_sync = value[7:0];
  endtask

  task automatic configure(logic [7:0] sync_b, logic [15:0] tmo);
    drain();
    cfg_write(slsfr_pkg::REG_SYNC_VALUE, {24'd0, sync_b});
    cfg_write(slsfr_pkg::REG_TIMEOUT_TICKS, {16'd0, tmo});
  endtask

  // One frame byte, sometimes preceded by a timer tick.
  task automatic frame_byte(logic [7:0] b);
    if ($urandom_range(99) < tick_pct) begin
      send_item(REQ_TICK, 8'd0);
      frame_items++;
    end
    send_item(REQ_BYTE, b);
    frame_items++;
  endtask

  // Mostly short well-formed frames; some bad checksums, zero lengths and cut frames.
  task automatic send_random_frame();
    int         r;
    int         cut;
    int         i;
    logic [7:0] len_b;
    logic [7:0] sum;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 4) len_b = 8'd0;
    else if (r < 12) len_b = 8'd1;
    else if (r < 95) len_b = 8'($urandom_range(2, 12));
    else len_b = 8'($urandom_range(13, 255));
    cut = ($urandom_range(99) < 5) ? $urandom_range(0, int'(len_b)) : -1;
    frame_byte(cur_sync);
    frame_byte(len_b);
    if (len_b == 8'd0) return;
    sum = len_b;
    for (i = 0; i < int'(len_b) - 1; i++) begin
      if (i == cut) return;
      b = ($urandom_range(9) == 0) ? cur_sync : 8'($urandom);
      sum = sum + b;
      frame_byte(b);
    end
    frame_byte(($urandom_range(99) < 85) ? sum : 8'($urandom));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) send_item(1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic run_random(int n_items);
    frame_items = 0;
    while (frame_items < n_items) begin
      if ($urandom_range(99) < 25) send_noise();
      send_random_frame();
    end
  endtask

  // Main sequence.
  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tuser  <= 1'b0;
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, zero length, length one, sync value as payload.
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h03);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, 8'hAC);

    // Directed: timeout while waiting for the length and inside the payload.
    configure(8'hAA, 16'd1);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h02);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h02);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h55);

    // Lowest register values; any tick inside a frame ends it.
    configure(8'h00, 16'd0);
    tick_pct = 2;
    run_random(200);
    // Receiver holds off while frames keep coming, so the input backs up.
    hold_reqs = hold_reqs + 1;
    run_random(80);

    // Highest register values; timeouts never happen.
    configure(8'hFF, 16'hFFFF);
    tick_pct = 10;
    run_random(300);

    // Sender stalls most of the time, receiver seldom.
    tx_idle_pct = 79;
    rx_idle_pct = 17;
    configure(8'($urandom), 16'($urandom_range(2, 12)));
    tick_pct = 8;
    run_random(650);

    // No stalls on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(8'hAA, 16'd40);
    tick_pct = 6;
    run_random(650);

    // A long quiet stretch past the limit still aborts the frame on its next byte.
    configure(8'hAA, 16'd100);
    send_item(REQ_BYTE, 8'hAA);
    repeat (LATE_TICKS) send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h03);
    send_item(REQ_BYTE, 8'hAA);
    send_item(REQ_BYTE, 8'h01);
    send_item(REQ_BYTE, 8'h01);

    drain();
    $display("covered %0d input items and %0d output items over seven register settings",
             sb.rx_items, sb.tx_items);
    $display("payload %0d, accepted %0d, checksum errors %0d, timeouts %0d, length errors %0d",
             sb.kind_seen[slsfr_pkg::KIND_PAYLOAD], sb.kind_seen[slsfr_pkg::KIND_ACCEPT],
             sb.kind_seen[slsfr_pkg::KIND_CHKERR], sb.kind_seen[slsfr_pkg::KIND_TIMEOUT],
             sb.kind_seen[slsfr_pkg::KIND_LENERR]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d items never delivered", sb.mismatches,
               sb.outstanding());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
